@@ hdl/fpjr_pkg.sv @@
// ---------------------------------------------------------------------------
// fpjr_pkg
// Shared types and constants of the feeder PID controller with jam reverse.
// ---------------------------------------------------------------------------
package fpjr_pkg;

   localparam int SPEED_W  = 16;   // speed samples, setpoint, command
   localparam int GAIN_W   = 16;   // unsigned Q8.8 gains
   localparam int OLIM_W   = 15;   // output clamp
   localparam int ILIM_W   = 23;   // error-sum clamp
   localparam int ERR_W    = 17;   // setpoint - measured
   localparam int SUM_W    = 24;   // accumulated error
   localparam int PHASE_W  = 9;    // tick counter
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 23;

   // Register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] REG_SETPOINT  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_STUCK_THR = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN_P    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN_I    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN_D    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_OUT_LIM   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_INT_LIM   = 3'd6;

   // Reset values of the registers
   localparam logic signed [SPEED_W-1:0] SETPOINT_RST  = 16'sd3000;
   localparam logic signed [SPEED_W-1:0] STUCK_THR_RST = 16'sd100;
   localparam logic [OLIM_W-1:0]         OUT_LIM_RST   = 15'h7FFF;
   localparam logic [ILIM_W-1:0]         INT_LIM_RST   = 23'h7FFFFF;

   // Drive applied while backing out of a jam
   localparam logic signed [SPEED_W-1:0] REVERSE_CMD = -16'sd2000;

   typedef struct packed {
      logic signed [SPEED_W-1:0] setpoint;
      logic signed [SPEED_W-1:0] stuck_thr;
      logic [GAIN_W-1:0]         gain_p;
      logic [GAIN_W-1:0]         gain_i;
      logic [GAIN_W-1:0]         gain_d;
      logic [OLIM_W-1:0]         out_lim;
      logic [ILIM_W-1:0]         int_lim;
   } csr_type;

   typedef struct packed {
      logic signed [SPEED_W-1:0] cmd;       // clamped command
      logic                      sat;       // output was clamped
      logic signed [ERR_W-1:0]   err;       // error of this step
      logic signed [SUM_W-1:0]   sum_nxt;   // updated error sum
   } pid_out_type;

   typedef enum logic [3:0] {
      MODE_IDLE    = 4'b0001,
      MODE_PID     = 4'b0010,
      MODE_CHECK   = 4'b0100,
      MODE_REVERSE = 4'b1000
   } mode_type;

endpackage

@@ hdl/fpjr_csr.sv @@
// ---------------------------------------------------------------------------
// fpjr_csr
// Configuration register file; a write completes in the cycle it is offered.
// ---------------------------------------------------------------------------
module fpjr_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [fpjr_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [fpjr_pkg::CSR_DATA_W-1:0]     csr_data,
   output fpjr_pkg::csr_type                   cfg
);

   fpjr_pkg::csr_type cfg_ff;
   fpjr_pkg::csr_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            fpjr_pkg::REG_SETPOINT:  cfg_in.setpoint  = $signed(csr_data[15:0]);
            fpjr_pkg::REG_STUCK_THR: cfg_in.stuck_thr = $signed(csr_data[15:0]);
            fpjr_pkg::REG_GAIN_P:    cfg_in.gain_p    = csr_data[15:0];
            fpjr_pkg::REG_GAIN_I:    cfg_in.gain_i    = csr_data[15:0];
            fpjr_pkg::REG_GAIN_D:    cfg_in.gain_d    = csr_data[15:0];
            fpjr_pkg::REG_OUT_LIM:   cfg_in.out_lim   = csr_data[14:0];
            fpjr_pkg::REG_INT_LIM:   cfg_in.int_lim   = csr_data[22:0];
            default: ;  // drop writes to unknown indexes
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.setpoint  <= fpjr_pkg::SETPOINT_RST;
         cfg_ff.stuck_thr <= fpjr_pkg::STUCK_THR_RST;
         cfg_ff.gain_p    <= '0;
         cfg_ff.gain_i    <= '0;
         cfg_ff.gain_d    <= '0;
         cfg_ff.out_lim   <= fpjr_pkg::OUT_LIM_RST;
         cfg_ff.int_lim   <= fpjr_pkg::INT_LIM_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ hdl/fpjr_pid.sv @@
// ---------------------------------------------------------------------------
// fpjr_pid
// One PID step in Q8.8: three products, output clamp, anti-windup sum update.
// ---------------------------------------------------------------------------
module fpjr_pid (
   input  logic signed [fpjr_pkg::SPEED_W-1:0] meas,
   input  fpjr_pkg::csr_type                   cfg,
   input  logic signed [fpjr_pkg::ERR_W-1:0]   prev_err,
   input  logic signed [fpjr_pkg::SUM_W-1:0]   err_sum,
   output fpjr_pkg::pid_out_type               pid
);

   logic signed [16:0] err;
   logic signed [17:0] diff;
   logic signed [24:0] isum;
   logic signed [16:0] gp_s;
   logic signed [16:0] gi_s;
   logic signed [16:0] gd_s;
   logic signed [33:0] prod_p;
   logic signed [34:0] prod_d;
   logic signed [41:0] prod_i;
   logic signed [43:0] total;
   logic signed [43:0] lim;
   logic               over_hi;
   logic               over_lo;
   logic signed [24:0] acc;
   logic signed [24:0] ilim;

   always_comb begin
      err  = 17'(cfg.setpoint) - 17'(meas);
      diff = 18'(err) - 18'(prev_err);
      isum = 25'(err) + 25'(err_sum);

      gp_s = $signed({1'b0, cfg.gain_p});
      gi_s = $signed({1'b0, cfg.gain_i});
      gd_s = $signed({1'b0, cfg.gain_d});

      prod_p = 34'(gp_s) * 34'(err);
      prod_d = 35'(gd_s) * 35'(diff);
      prod_i = 42'(gi_s) * 42'(isum);

      total = 44'(prod_p) + 44'(prod_d) + 44'(prod_i);
      lim   = $signed(44'({cfg.out_lim, 8'h00}));

      over_hi = (total > lim);
      over_lo = (total < -lim);

      pid.err = err;
      pid.sat = over_hi | over_lo;
      if (over_hi) begin
         pid.cmd = $signed({1'b0, cfg.out_lim});
      end else if (over_lo) begin
         pid.cmd = -$signed({1'b0, cfg.out_lim});
      end else begin
         // arithmetic shift: floor of total / 256
         pid.cmd = total[23:8];
      end

      // anti-windup: clear on saturation, else accumulate and clamp
      acc  = 25'(err_sum) + 25'(err);
      ilim = $signed(25'({2'b00, cfg.int_lim}));
      if (acc > ilim) begin
         acc = ilim;
      end else if (acc < -ilim) begin
         acc = -ilim;
      end
      pid.sum_nxt = pid.sat ? '0 : acc[23:0];
   end

endmodule

@@ hdl/feeder_pid_with_jam_reverse.sv @@
// ---------------------------------------------------------------------------
// feeder_pid_with_jam_reverse
// Feeder speed PID burst controller with jam detection and reverse drive.
// ---------------------------------------------------------------------------
// Datapath: input register, then result register, which drives rsp_tvalid.
// Throughput: one item per cycle while rsp_tready does not stall the result; the PID
// step and mode update for an item are combinational between the two registers.
// Reset: synchronous, active high; restores register defaults, clears PID
// state, counter and held command, and returns the mode to idle.
module feeder_pid_with_jam_reverse #(
   parameter int PID_TICKS     = 100,
   parameter int REVERSE_TICKS = 300
) (
   input  logic        clock,
   input  logic        reset,
   // input stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,    // [15:0] measured_speed
   input  logic [0:0]  req_tuser,    // [0] fire_request
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,    // [15:0] speed_command
   output logic [1:0]  rsp_tuser,    // [0] output_saturated, [1] reversing
   // configuration
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [22:0] csr_data
);

   localparam int PW = fpjr_pkg::PHASE_W;
   localparam logic [PW-1:0] PID_LIM = PW'(PID_TICKS);
   localparam logic [PW-1:0] REV_LIM = PW'(REVERSE_TICKS);

   fpjr_pkg::csr_type     cfg;
   fpjr_pkg::pid_out_type pid;

   // input register
   logic               in_vld_ff;
   logic signed [15:0] in_meas_ff;
   logic               in_fire_ff;

   // controller state
   fpjr_pkg::mode_type          mode_ff, mode_in;
   logic [PW-1:0]               phase_ff, phase_in;
   logic signed [16:0]          prev_err_ff, prev_err_in;
   logic signed [23:0]          err_sum_ff, err_sum_in;
   logic signed [15:0]          held_ff, held_in;
   logic                        sat_in;
   logic                        rev_in;
   logic                        pid_run;

   // result register
   logic        rsp_vld_ff;
   logic [15:0] rsp_data_ff;
   logic [1:0]  rsp_user_ff;

   logic req_xfer;
   logic adv;

   fpjr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   fpjr_pid u_pid (
      .meas     (in_meas_ff),
      .cfg      (cfg),
      .prev_err (prev_err_ff),
      .err_sum  (err_sum_ff),
      .pid      (pid)
   );

   // advance a held input when the result slot is free or being emptied
   assign adv        = in_vld_ff & (~rsp_vld_ff | rsp_tready);
   assign req_tready = ~in_vld_ff | adv;
   assign req_xfer   = req_tvalid & req_tready;

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   always_comb begin
      mode_in = mode_ff;
      phase_in = phase_ff;
      held_in = held_ff;
      rev_in  = 1'b0;
      pid_run = 1'b0;
      unique case (mode_ff)
         fpjr_pkg::MODE_PID: begin
            pid_run  = 1'b1;
            held_in  = pid.cmd;
            phase_in = phase_ff + PW'(1);
            if (phase_in >= PID_LIM) begin
               mode_in = fpjr_pkg::MODE_CHECK;
            end
         end
         fpjr_pkg::MODE_CHECK: begin
            if (in_meas_ff < cfg.stuck_thr) begin
               held_in  = fpjr_pkg::REVERSE_CMD;
               rev_in   = 1'b1;
               phase_in = PW'(1);
               mode_in  = (REV_LIM <= PW'(1)) ? fpjr_pkg::MODE_IDLE
                                              : fpjr_pkg::MODE_REVERSE;
            end else begin
               // keep the last PID command for this tick
               mode_in  = fpjr_pkg::MODE_IDLE;
               phase_in = '0;
            end
         end
         fpjr_pkg::MODE_REVERSE: begin
            held_in  = fpjr_pkg::REVERSE_CMD;
            rev_in   = 1'b1;
            phase_in = phase_ff + PW'(1);
            if (phase_in >= REV_LIM) begin
               mode_in  = fpjr_pkg::MODE_IDLE;
               phase_in = '0;
            end
         end
         default: begin
            if (in_fire_ff) begin
               pid_run  = 1'b1;
               held_in  = pid.cmd;
               phase_in = PW'(1);
               mode_in  = (PID_LIM <= PW'(1)) ? fpjr_pkg::MODE_CHECK
                                              : fpjr_pkg::MODE_PID;
            end else begin
               held_in  = '0;
               phase_in = '0;
               mode_in  = fpjr_pkg::MODE_IDLE;
            end
         end
      endcase
      sat_in      = pid_run & pid.sat;
      prev_err_in = pid_run ? pid.err : prev_err_ff;
      err_sum_in  = pid_run ? pid.sum_nxt : err_sum_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_xfer) begin
         in_vld_ff <= 1'b1;
      end else if (adv) begin
         in_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_meas_ff <= $signed(req_tdata);
         in_fire_ff <= req_tuser[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= fpjr_pkg::MODE_IDLE;
         phase_ff    <= '0;
         prev_err_ff <= '0;
         err_sum_ff  <= '0;
         held_ff     <= '0;
      end else if (adv) begin
         mode_ff     <= mode_in;
         phase_ff    <= phase_in;
         prev_err_ff <= prev_err_in;
         err_sum_ff  <= err_sum_in;
         held_ff     <= held_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (adv) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_data_ff <= held_in;
         rsp_user_ff <= {rev_in, sat_in};
      end
   end

endmodule

@@ tb/sv/testbench.sv @@
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for the feeder PID burst controller with jam reverse.
// A table of directed ticks and register writes runs first. Random setting
// phases follow, each with a burst-heavy tick stream. Every result transfer
// is checked field by field against an in-bench model of the controller or a fixed table value.
// ---------------------------------------------------------------------------
module testbench;

   localparam int PID_TICKS     = 100;
   localparam int REVERSE_TICKS = 300;
   localparam int RAND_PHASES   = 5;
   localparam int PHASE_TICKS   = 50;

   localparam logic [fpjr_pkg::CSR_IDX_W-1:0] REG_UNUSED = 3'd7;
   localparam logic [fpjr_pkg::CSR_IDX_W-1:0] REG_ORDER [8] = '{
      fpjr_pkg::REG_SETPOINT, fpjr_pkg::REG_STUCK_THR, fpjr_pkg::REG_GAIN_P,
      fpjr_pkg::REG_GAIN_I, fpjr_pkg::REG_GAIN_D, fpjr_pkg::REG_OUT_LIM,
      fpjr_pkg::REG_INT_LIM, REG_UNUSED};

   localparam logic signed [fpjr_pkg::SPEED_W-1:0] SPEED_MIN = 16'sh8000;
   localparam logic signed [fpjr_pkg::SPEED_W-1:0] SPEED_MAX = 16'sh7FFF;

   typedef struct packed {
      logic signed [fpjr_pkg::SPEED_W-1:0] speed_command;
      logic                                output_saturated;
      logic                                reversing;
   } feeder_out_type;

   localparam feeder_out_type ZERO_OUT  = '{16'sd0, 1'b0, 1'b0};
   localparam feeder_out_type REV_OUT   = '{fpjr_pkg::REVERSE_CMD, 1'b0, 1'b1};
   localparam feeder_out_type CLAMP_OUT = '{16'sd1000, 1'b1, 1'b0};

   typedef enum logic {ROW_TICK, ROW_WRITE} row_kind_type;

   typedef struct {
      row_kind_type                        kind;
      logic [fpjr_pkg::CSR_IDX_W-1:0]      index;
      logic [fpjr_pkg::CSR_DATA_W-1:0]     value;
      logic signed [fpjr_pkg::SPEED_W-1:0] speed;
      logic                                fire;
      int                                  reps;
      bit                                  fixed_want;
      feeder_out_type                      want;
   } plan_row_type;

   localparam int PLAN_LEN = 33;

   // Upper data bits on writes are junk that the block must drop.
   plan_row_type plan [PLAN_LEN] = '{
      '{ROW_TICK,  '0, '0, 16'sd0,    1'b0, 1,   1'b1, ZERO_OUT},
      '{ROW_TICK,  '0, '0, SPEED_MIN, 1'b0, 1,   1'b1, ZERO_OUT},
      '{ROW_TICK,  '0, '0, SPEED_MAX, 1'b1, 1,   1'b1, ZERO_OUT},
      '{ROW_TICK,  '0, '0, 16'sd0,    1'b1, 99,  1'b1, ZERO_OUT},
      '{ROW_TICK,  '0, '0, SPEED_MIN, 1'b0, 1,   1'b1, REV_OUT},
      '{ROW_TICK,  '0, '0, SPEED_MAX, 1'b1, 299, 1'b1, REV_OUT},
      '{ROW_TICK,  '0, '0, 16'sd0,    1'b0, 1,   1'b1, ZERO_OUT},
      '{ROW_WRITE, fpjr_pkg::REG_GAIN_P,    23'h7F0100, 16'sd0, 1'b0, 0, 1'b0, ZERO_OUT},
      '{ROW_WRITE, fpjr_pkg::REG_OUT_LIM,   23'h0083E8, 16'sd0, 1'b0, 0, 1'b0, ZERO_OUT},
      '{ROW_TICK,  '0, '0, 16'sd0,    1'b1, 1,   1'b1, CLAMP_OUT},
      '{ROW_TICK,  '0, '0, 16'sd2500, 1'b0, 19,  1'b0, ZERO_OUT},
      '{ROW_WRITE, fpjr_pkg::REG_GAIN_P,    23'h00FFFF, 16'sd0, 1'b0, 0, 1'b0, ZERO_OUT},
      '{ROW_WRITE, fpjr_pkg::REG_GAIN_I,    23'h00FFFF, 16'sd0, 1'b0, 0, 1'b0, ZERO_OUT},
      '{ROW_WRITE, fpjr_pkg::REG_GAIN_D,    23'h00FFFF, 16'sd0, 1'b0, 0, 1'b0, ZERO_OUT},
      '{ROW_WRITE, fpjr_pkg::REG_OUT_LIM,   23'h007FFF, 16'sd0, 1'b0, 0, 1'b0, ZERO_OUT},
      '{ROW_WRITE, fpjr_pkg::REG_INT_LIM,   23'h7FFFFF, 16'sd0, 1'b0, 0, 1'b0, ZERO_OUT},
      '{ROW_WRITE, fpjr_pkg::REG_SETPOINT,  23'h008000, 16'sd0, 1'b0, 0, 1'b0, ZERO_OUT},
      '{ROW_WRITE, fpjr_pkg::REG_STUCK_THR, 23'h008000, 16'sd0, 1'b0, 0, 1'b0, ZERO_OUT},
      '{ROW_TICK,  '0, '0, SPEED_MAX, 1'b1, 20,  1'b0, ZERO_OUT},
      '{ROW_TICK,  '0, '0, SPEED_MIN, 1'b0, 20,  1'b0, ZERO_OUT},
      '{ROW_WRITE, fpjr_pkg::REG_SETPOINT,  23'h000000, 16'sd0, 1'b0, 0, 1'b0, ZERO_OUT},
      '{ROW_WRITE, fpjr_pkg::REG_GAIN_P,    23'h000000, 16'sd0, 1'b0, 0, 1'b0, ZERO_OUT},
      '{ROW_WRITE, fpjr_pkg::REG_GAIN_D,    23'h000000, 16'sd0, 1'b0, 0, 1'b0, ZERO_OUT},
      '{ROW_WRITE, fpjr_pkg::REG_GAIN_I,    23'h000001, 16'sd0, 1'b0, 0, 1'b0, ZERO_OUT},
      '{ROW_WRITE, fpjr_pkg::REG_INT_LIM,   23'h000005, 16'sd0, 1'b0, 0, 1'b0, ZERO_OUT},
      '{ROW_WRITE, fpjr_pkg::REG_STUCK_THR, 23'h007FFF, 16'sd0, 1'b0, 0, 1'b0, ZERO_OUT},
      '{ROW_WRITE, REG_UNUSED,              23'h7FFFFF, 16'sd0, 1'b0, 0, 1'b0, ZERO_OUT},
      '{ROW_TICK,  '0, '0, 16'sd3,    1'b1, 20,  1'b0, ZERO_OUT},
      '{ROW_WRITE, fpjr_pkg::REG_OUT_LIM,   23'h000000, 16'sd0, 1'b0, 0, 1'b0, ZERO_OUT},
      '{ROW_WRITE, fpjr_pkg::REG_GAIN_P,    23'h000001, 16'sd0, 1'b0, 0, 1'b0, ZERO_OUT},
      '{ROW_TICK,  '0, '0, -16'sd1,   1'b1, 20,  1'b0, ZERO_OUT},
      '{ROW_TICK,  '0, '0, SPEED_MAX, 1'b0, 1,   1'b0, ZERO_OUT},
      '{ROW_TICK,  '0, '0, 16'sd0,    1'b0, 1,   1'b1, ZERO_OUT}
   };

   logic                              clock;
   logic                              reset      = 1'b1;
   logic                              req_tvalid = 1'b0;
   logic                              req_tready;
   logic [15:0]                       req_tdata  = '0;   // [15:0] measured_speed
   logic [0:0]                        req_tuser  = '0;   // [0] fire_request
   logic                              rsp_tvalid;
   logic                              rsp_tready = 1'b1;
   logic [15:0]                       rsp_tdata;         // [15:0] speed_command
   logic [1:0]                        rsp_tuser;   // [0] output_saturated, [1] reversing
   logic                              csr_valid  = 1'b0;
   logic                              csr_ready;
   logic [fpjr_pkg::CSR_IDX_W-1:0]    csr_index  = '0;
   logic [fpjr_pkg::CSR_DATA_W-1:0]   csr_data   = '0;

   // Controller model: settings and state
   logic signed [fpjr_pkg::SPEED_W-1:0] cfg_setpoint  = fpjr_pkg::SETPOINT_RST;
   logic signed [fpjr_pkg::SPEED_W-1:0] cfg_stuck_thr = fpjr_pkg::STUCK_THR_RST;
   logic [fpjr_pkg::GAIN_W-1:0]         cfg_gain_p    = '0;
   logic [fpjr_pkg::GAIN_W-1:0]         cfg_gain_i    = '0;
   logic [fpjr_pkg::GAIN_W-1:0]         cfg_gain_d    = '0;
   logic [fpjr_pkg::OLIM_W-1:0]         cfg_out_lim   = fpjr_pkg::OUT_LIM_RST;
   logic [fpjr_pkg::ILIM_W-1:0]         cfg_int_lim   = fpjr_pkg::INT_LIM_RST;

   logic signed [fpjr_pkg::ERR_W-1:0]   last_error    = '0;
   logic signed [fpjr_pkg::SUM_W-1:0]   error_total   = '0;
   logic [fpjr_pkg::PHASE_W-1:0]        tick_count    = '0;
   fpjr_pkg::mode_type                  feeder_mode   = fpjr_pkg::MODE_IDLE;
   logic signed [fpjr_pkg::SPEED_W-1:0] drive_command = '0;

   feeder_out_type expected_commands [$];
   feeder_out_type want_cmd;
   int          mismatches = 0;
   int          n_ticks    = 0;
   int          n_checked  = 0;
   int          n_writes   = 0;
   int          n_sat      = 0;
   int          n_reverse  = 0;
   int          stall_left = 0;
   bit          no_idle    = 1'b0;

   feeder_pid_with_jam_reverse #(
      .PID_TICKS     (PID_TICKS),
      .REVERSE_TICKS (REVERSE_TICKS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #1000000;
      $display("testbench: FAIL");
      $finish;
   end

   function automatic int idle_len();
      if ($urandom_range(0, 19) < 15) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic void store_register(input logic [fpjr_pkg::CSR_IDX_W-1:0] idx,
                                          input logic [fpjr_pkg::CSR_DATA_W-1:0] data);
      case (idx)
         fpjr_pkg::REG_SETPOINT:  cfg_setpoint  = data[fpjr_pkg::SPEED_W-1:0];
         fpjr_pkg::REG_STUCK_THR: cfg_stuck_thr = data[fpjr_pkg::SPEED_W-1:0];
         fpjr_pkg::REG_GAIN_P:    cfg_gain_p    = data[fpjr_pkg::GAIN_W-1:0];
         fpjr_pkg::REG_GAIN_I:    cfg_gain_i    = data[fpjr_pkg::GAIN_W-1:0];
         fpjr_pkg::REG_GAIN_D:    cfg_gain_d    = data[fpjr_pkg::GAIN_W-1:0];
         fpjr_pkg::REG_OUT_LIM:   cfg_out_lim   = data[fpjr_pkg::OLIM_W-1:0];
         fpjr_pkg::REG_INT_LIM:   cfg_int_lim   = data[fpjr_pkg::ILIM_W-1:0];
         default: ;
      endcase
   endfunction

   // One Q8.8 PID step: returns the clamped command, flags a clamp, and
   // updates the error history and the anti-windup sum.
   function automatic logic signed [fpjr_pkg::SPEED_W-1:0] pid_command(
         input logic signed [fpjr_pkg::SPEED_W-1:0] speed, output logic clamped);
      longint err, acc, lim, sum;
      logic signed [fpjr_pkg::SPEED_W-1:0] cmd;
      err = longint'(cfg_setpoint) - longint'(speed);
      acc = longint'(cfg_gain_p) * err
          + longint'(cfg_gain_d) * (err - longint'(last_error))
          + longint'(cfg_gain_i) * (err + longint'(error_total));
      lim = longint'(cfg_out_lim) * 256;
      clamped = 1'b1;
      if (acc > lim) begin
         cmd = {1'b0, cfg_out_lim};
      end else if (acc < -lim) begin
         cmd = -$signed({1'b0, cfg_out_lim});
      end else begin
         cmd = fpjr_pkg::SPEED_W'(acc >>> 8);
         clamped = 1'b0;
      end
      if (clamped) begin
         error_total = '0;
      end else begin
         sum = longint'(error_total) + err;
         if (sum > longint'(cfg_int_lim)) sum = longint'(cfg_int_lim);
         if (sum < -longint'(cfg_int_lim)) sum = -longint'(cfg_int_lim);
         error_total = fpjr_pkg::SUM_W'(sum);
      end
      last_error = fpjr_pkg::ERR_W'(err);
      return cmd;
   endfunction

   function automatic feeder_out_type predict_tick(
         input logic signed [fpjr_pkg::SPEED_W-1:0] speed, input logic fire);
      logic sat, rev;
      sat = 1'b0;
      rev = 1'b0;
      case (feeder_mode)
         fpjr_pkg::MODE_PID: begin
            drive_command = pid_command(speed, sat);
            tick_count = tick_count + 1'b1;
            if (tick_count >= PID_TICKS) feeder_mode = fpjr_pkg::MODE_CHECK;
         end
         fpjr_pkg::MODE_CHECK: begin
            if (speed < cfg_stuck_thr) begin
               drive_command = fpjr_pkg::REVERSE_CMD;
               rev = 1'b1;
               tick_count = fpjr_pkg::PHASE_W'(1);
               feeder_mode = (tick_count >= REVERSE_TICKS) ? fpjr_pkg::MODE_IDLE
                                                           : fpjr_pkg::MODE_REVERSE;
            end else begin
               feeder_mode = fpjr_pkg::MODE_IDLE;
               tick_count = '0;
            end
         end
         fpjr_pkg::MODE_REVERSE: begin
            drive_command = fpjr_pkg::REVERSE_CMD;
            rev = 1'b1;
            tick_count = tick_count + 1'b1;
            if (tick_count >= REVERSE_TICKS) begin
               feeder_mode = fpjr_pkg::MODE_IDLE;
               tick_count = '0;
            end
         end
         default: begin
            if (fire) begin
               drive_command = pid_command(speed, sat);
               tick_count = fpjr_pkg::PHASE_W'(1);
               feeder_mode = (tick_count >= PID_TICKS) ? fpjr_pkg::MODE_CHECK
                                                       : fpjr_pkg::MODE_PID;
            end else begin
               drive_command = '0;
               tick_count = '0;
               feeder_mode = fpjr_pkg::MODE_IDLE;
            end
         end
      endcase
      return '{drive_command, sat, rev};
   endfunction

   function automatic logic signed [fpjr_pkg::SPEED_W-1:0] pick_speed();
      int r, v;
      r = $urandom_range(0, 9);
      if (r < 5) begin
         // stay near the setpoint so the loop does not saturate every tick
         v = $urandom_range(0, 600);
         v = int'(cfg_setpoint) + v - 300;
         if (v > 32767) v = 32767;
         if (v < -32768) v = -32768;
         return v[15:0];
      end
      if (r < 9) return fpjr_pkg::SPEED_W'($urandom());
      return $urandom_range(0, 1) ? SPEED_MAX : SPEED_MIN;
   endfunction

   function automatic logic [fpjr_pkg::CSR_DATA_W-1:0] pick_reg_value(
         input logic [fpjr_pkg::CSR_IDX_W-1:0] idx);
      logic [fpjr_pkg::CSR_DATA_W-1:0] junk;
      int sel, v;
      junk = fpjr_pkg::CSR_DATA_W'($urandom());
      sel = $urandom_range(0, 3);
      case (idx)
         fpjr_pkg::REG_SETPOINT, fpjr_pkg::REG_STUCK_THR: begin
            v = $urandom_range(0, 8000);
            v = (sel == 0) ? -32768 : (sel == 1) ? 32767 : v - 4000;
            return {junk[22:16], v[15:0]};
         end
         fpjr_pkg::REG_GAIN_P, fpjr_pkg::REG_GAIN_I, fpjr_pkg::REG_GAIN_D: begin
            v = (sel == 0) ? 0 : (sel == 1) ? 65535 : $urandom_range(0, 768);
            return {junk[22:16], v[15:0]};
         end
         fpjr_pkg::REG_OUT_LIM: begin
            v = (sel == 0) ? 0 : (sel == 1) ? 32767 : $urandom_range(1, 8000);
            return {junk[22:15], v[14:0]};
         end
         fpjr_pkg::REG_INT_LIM: begin
            v = (sel == 0) ? 0 : (sel == 1) ? 8388607 : $urandom_range(0, 200000);
            return v[22:0];
         end
         default: return junk;
      endcase
   endfunction

   task automatic send_tick(input logic signed [fpjr_pkg::SPEED_W-1:0] speed,
                            input logic fire,
                            input bit use_fixed, input feeder_out_type fixed_val);
      feeder_out_type predicted;
      int gap;
      gap = (no_idle || $urandom_range(0, 3) != 0) ? 0 : idle_len();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= speed;
      req_tuser  <= fire;
      do @(posedge clock); while (!req_tready);
      predicted = predict_tick(speed, fire);
      expected_commands.push_back(use_fixed ? fixed_val : predicted);
      n_ticks++;
   endtask

   // Enter with no write pending; always idles before driving the write.
   task automatic write_reg(input logic [fpjr_pkg::CSR_IDX_W-1:0] idx,
                            input logic [fpjr_pkg::CSR_DATA_W-1:0] data);
      repeat (1 + $urandom_range(0, 3)) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      store_register(idx, data);
      n_writes++;
      csr_valid <= 1'b0;
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (expected_commands.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_commands.size() == 0) begin
            $error("rsp: result transfer with no expected command pending");
            mismatches++;
         end else begin
            want_cmd = expected_commands.pop_front();
            n_checked++;
            if (want_cmd.output_saturated) n_sat++;
            if (want_cmd.reversing) n_reverse++;
            if (rsp_tdata !== want_cmd.speed_command) begin
               $error("speed_command: expected %0d, actual %0d",
                      want_cmd.speed_command, $signed(rsp_tdata));
               mismatches++;
            end
            if (rsp_tuser[0] !== want_cmd.output_saturated) begin
               $error("output_saturated: expected %0d, actual %0d",
                      want_cmd.output_saturated, rsp_tuser[0]);
               mismatches++;
            end
            if (rsp_tuser[1] !== want_cmd.reversing) begin
               $error("reversing: expected %0d, actual %0d",
                      want_cmd.reversing, rsp_tuser[1]);
               mismatches++;
            end
         end
      end
      if (stall_left != 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         if (!no_idle && $urandom_range(0, 9) == 0) stall_left = idle_len();
      end
   end

   initial begin
      int n;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         if (plan[i].kind == ROW_WRITE) begin
            drain_results();
            write_reg(plan[i].index, plan[i].value);
         end else begin
            repeat (plan[i].reps)
               send_tick(plan[i].speed, plan[i].fire, plan[i].fixed_want, plan[i].want);
         end
      end

      n = 0;
      for (int ph = 0; ph < RAND_PHASES; ph++) begin
         drain_results();
         foreach (REG_ORDER[r]) write_reg(REG_ORDER[r], pick_reg_value(REG_ORDER[r]));
         repeat (PHASE_TICKS) begin
            // switch between idling and back-to-back stretches
            if (n % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
            send_tick(pick_speed(), $urandom_range(0, 3) != 0, 1'b0, ZERO_OUT);
            n++;
         end
      end
      drain_results();

      $display("summary: %0d ticks sent, %0d register writes over %0d random settings",
               n_ticks, n_writes, RAND_PHASES);
      $display("summary: %0d results checked, %0d clamped, %0d on jam reverse",
               n_checked, n_sat, n_reverse);
      if (mismatches == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule
